### design/imm_pkg.sv
`default_nettype none

package imm_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_DIM_DEF    = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the ports.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned REG_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INDEX_ERR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DIM_ERR   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;    // clear the accumulator
    logic issue;  // operand reads were issued this cycle
  } mac_ctrl_t;

endpackage

`default_nettype wire

### design/imm_ram.sv
`default_nettype none

module imm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### design/imm_store.sv
`default_nettype none

// One matrix store: a RAM plus a written flag per entry so that entries never
// written since reset read as zero.
module imm_store #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [DEPTH-1:0] written_q;
  logic             rd_written_q;
  logic [WIDTH-1:0] ram_rdata;

  imm_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .re_i   (re_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_written_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_written_q ? ram_rdata : '0;

endmodule

`default_nettype wire

### design/imm_mac.sv
`default_nettype none

// Shared multiply-accumulate unit. Operands arrive in the cycle after the read
// issue, the product is registered, and the following cycle adds it in.
module imm_mac
  import imm_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mac_ctrl_t             ctrl_i,
  input  wire logic [DATA_WIDTH-1:0] a_i,
  input  wire logic [DATA_WIDTH-1:0] b_i,
  output logic      [DATA_WIDTH-1:0] acc_o,
  output logic                       busy_o
);

  logic                  opnd_vld_q;
  logic                  prod_vld_q;
  logic [DATA_WIDTH-1:0] prod_q;
  logic [DATA_WIDTH-1:0] prod_d;
  logic [DATA_WIDTH-1:0] acc_q;

  // Only the low bits of the product are kept, so signedness does not matter.
  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opnd_vld_q <= 1'b0;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      opnd_vld_q <= ctrl_i.issue;
      prod_vld_q <= opnd_vld_q;
      if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + prod_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (opnd_vld_q) begin
      prod_q <= prod_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = opnd_vld_q | prod_vld_q;

endmodule

`default_nettype wire

### design/integer_matrix_multiply_top.sv
`default_nettype none

// Integer matrix multiplier. Element writes to A or B are taken one per cycle
// while idle and the output is not stalled, and produce a result only when
// the index lies outside the configured size. A compute command yields the
// rows-of-A by columns-of-B product elements in row-major order, the final
// one flagged by last_o; a mismatch between A's columns and B's rows yields
// a single dimension-error result the cycle after. Each product element sums
// over the inner dimension (inner = columns of A in use), a zero inner
// dimension gives a zero element, and output stalls hold the compute back.
// One shared multiply-accumulate unit fed by one read port per store does all
// the work, and the input stays not ready until the last element has been
// transferred out. Both stores read as zero after reset through per-entry
// written flags; there is no clearing pass.
module integer_matrix_multiply_top
  import imm_pkg::*;
#(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [REG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [FUNC_W-1:0]       func_i,
  input  wire logic [POS_W-1:0]        row_index_i,
  input  wire logic [POS_W-1:0]        col_index_i,
  input  wire logic signed [VAL_W-1:0] element_value_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic [POS_W-1:0]             out_row_o,
  output logic [POS_W-1:0]             out_col_o,
  output logic signed [VAL_W-1:0]      out_value_o,
  output logic                         last_o
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  state_e state_q;

  logic [REG_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [IDX_W-1:0] i_q, j_q, k_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [POS_W-1:0]    out_row_q, out_col_q;
  logic [VAL_W-1:0]    out_value_q;
  logic                last_q;

  logic [DIM_W-1:0] m_eff, inner_eff, b_rows_eff, n_eff;
  logic [DIM_W-1:0] w_rows_eff, w_cols_eff;
  logic             in_acc, out_free, is_write, is_compute, write_ok, dim_err;
  logic             k_last, j_last, i_last, emit;
  logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
  logic              a_we, b_we;
  mac_ctrl_t         mac_ctrl;
  logic [DATA_WIDTH-1:0] a_rdata, b_rdata, acc;
  logic signed [DATA_WIDTH-1:0] acc_s;
  logic                  mac_busy;

  function automatic logic [DIM_W-1:0] eff_dim(logic [REG_W-1:0] r);
    if (32'(r) > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(r);
  endfunction

  function automatic logic at_end(logic [IDX_W-1:0] c, logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] nxt;
    nxt = DIM_W'(c) + DIM_W'(1);
    return nxt == lim;
  endfunction

  always_comb begin
    m_eff      = eff_dim(a_rows_q);
    inner_eff  = eff_dim(a_cols_q);
    b_rows_eff = eff_dim(b_rows_q);
    n_eff      = eff_dim(b_cols_q);

    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == ST_IDLE) && out_free;
    in_acc     = in_valid_i && in_ready_o;

    is_write   = (func_i == FUNC_WRITE_A) || (func_i == FUNC_WRITE_B);
    is_compute = (func_i == FUNC_COMPUTE);
    w_rows_eff = (func_i == FUNC_WRITE_A) ? m_eff : b_rows_eff;
    w_cols_eff = (func_i == FUNC_WRITE_A) ? inner_eff : n_eff;
    write_ok   = (32'(row_index_i) < 32'(w_rows_eff)) &&
                 (32'(col_index_i) < 32'(w_cols_eff));
    dim_err    = inner_eff != b_rows_eff;

    waddr = ADDR_W'(IDX_W'(row_index_i)) * ADDR_W'(MAX_DIM) +
            ADDR_W'(IDX_W'(col_index_i));
    a_we  = in_acc && (func_i == FUNC_WRITE_A) && write_ok;
    b_we  = in_acc && (func_i == FUNC_WRITE_B) && write_ok;

    a_raddr = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
    b_raddr = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);

    k_last = at_end(k_q, inner_eff);
    j_last = at_end(j_q, n_eff);
    i_last = at_end(i_q, m_eff);
    emit   = (state_q == ST_WAIT) && !mac_busy && out_free;

    mac_ctrl.issue = (state_q == ST_RUN);
    // The accumulator restarts when a compute begins and after every element.
    mac_ctrl.clr   = emit || (in_acc && is_compute);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= REG_W'(1);
      a_cols_q <= REG_W'(1);
      b_rows_q <= REG_W'(1);
      b_cols_q <= REG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_ROWS: a_rows_q <= cfg_data_i;
        CFG_A_COLS: a_cols_q <= cfg_data_i;
        CFG_B_ROWS: b_rows_q <= cfg_data_i;
        CFG_B_COLS: b_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_value_q <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && is_write && !write_ok) begin
            out_valid_q <= 1'b1;
            status_q    <= STATUS_INDEX_ERR;
            out_row_q   <= row_index_i;
            out_col_q   <= col_index_i;
            out_value_q <= '0;
            last_q      <= 1'b1;
          end else if (in_acc && is_compute) begin
            i_q <= '0;
            j_q <= '0;
            k_q <= '0;
            if (dim_err) begin
              out_valid_q <= 1'b1;
              status_q    <= STATUS_DIM_ERR;
              out_row_q   <= '0;
              out_col_q   <= '0;
              out_value_q <= '0;
              last_q      <= 1'b1;
            end else if (m_eff != '0 && n_eff != '0) begin
              state_q <= (inner_eff == '0) ? ST_WAIT : ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= ST_WAIT;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        ST_WAIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            status_q    <= STATUS_OK;
            out_row_q   <= POS_W'(i_q);
            out_col_q   <= POS_W'(j_q);
            out_value_q <= VAL_W'(acc_s);
            last_q      <= i_last && j_last;
            if (j_last) begin
              j_q <= '0;
              i_q <= i_q + IDX_W'(1);
            end else begin
              j_q <= j_q + IDX_W'(1);
            end
            if (i_last && j_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= (inner_eff == '0) ? ST_WAIT : ST_RUN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign acc_s = $signed(acc);

  imm_store #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (a_we),
    .waddr_i(waddr),
    .wdata_i(element_value_i[DATA_WIDTH-1:0]),
    .re_i   (mac_ctrl.issue),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  imm_store #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_store_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (b_we),
    .waddr_i(waddr),
    .wdata_i(element_value_i[DATA_WIDTH-1:0]),
    .re_i   (mac_ctrl.issue),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  imm_mac #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mac_ctrl),
    .a_i   (a_rdata),
    .b_i   (b_rdata),
    .acc_o (acc),
    .busy_o(mac_busy)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

  // The accumulator pipeline only runs while a compute is in progress.
  a_mac_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_busy |-> (state_q != ST_IDLE))
    else $error("multiply-accumulate pipeline active while idle");

  // The inner counter never passes the inner dimension.
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (32'(k_q) < 32'(inner_eff)))
    else $error("inner index out of range");

  // Row counter stays inside A while a compute is in progress.
  a_i_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (32'(i_q) < 32'(m_eff)))
    else $error("row index out of range during compute");

  // A mismatched compute answers with a dimension error in the next cycle.
  a_dim_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_compute && dim_err) |=>
      (out_valid_q && (status_q == STATUS_DIM_ERR) && last_q && (state_q == ST_IDLE)))
    else $error("dimension mismatch not reported");

endmodule

`default_nettype wire

### sim/matmul_tracker_pkg.sv
package matmul_tracker_pkg;
  import imm_pkg::*;

  // Command code the block does not decode; it must be dropped silently.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [VAL_W-1:0]    value;
    logic                last;
  } mm_result_t;

  class matmul_tracker;
    logic [VAL_W-1:0] mat_a [MAX_DIM_DEF*MAX_DIM_DEF];
    logic [VAL_W-1:0] mat_b [MAX_DIM_DEF*MAX_DIM_DEF];
    logic [REG_W-1:0] dims [4];
    mm_result_t       results_due [$];
    int unsigned      errors;
    int unsigned      writes_done;
    int unsigned      computes_done;
    int unsigned      ignored_done;
    int unsigned      products_due;
    int unsigned      index_errs_due;
    int unsigned      dim_errs_due;

    function new();
      foreach (mat_a[i]) begin
        mat_a[i] = '0;
        mat_b[i] = '0;
      end
      foreach (dims[i]) dims[i] = 4'd1;
      errors         = 0;
      writes_done    = 0;
      computes_done  = 0;
      ignored_done   = 0;
      products_due   = 0;
      index_errs_due = 0;
      dim_errs_due   = 0;
    endfunction

    // Register values above the store size behave as the full size.
    function int unsigned dim_of(logic [REG_W-1:0] reg_value);
      return (reg_value > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(reg_value);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] reg_value);
      dims[idx] = reg_value;
    endfunction

    function int unsigned pending();
      return results_due.size();
    endfunction

    function void push_result(logic [STATUS_W-1:0] status, int unsigned row,
                              int unsigned col, logic [VAL_W-1:0] value, logic last);
      mm_result_t res;
      res.status = status;
      res.row    = POS_W'(row);
      res.col    = POS_W'(col);
      res.value  = value;
      res.last   = last;
      results_due.push_back(res);
    endfunction

    // Called for every command the block accepts, in order of transfer.
    function void apply_command(logic [FUNC_W-1:0] func, logic [POS_W-1:0] row,
                                logic [POS_W-1:0] col, logic [VAL_W-1:0] value);
      int unsigned n_rows, n_cols, m, inner, n;
      logic [VAL_W-1:0] acc;
      case (func)
        FUNC_WRITE_A, FUNC_WRITE_B: begin
          writes_done++;
          n_rows = dim_of(func == FUNC_WRITE_A ? dims[CFG_A_ROWS] : dims[CFG_B_ROWS]);
          n_cols = dim_of(func == FUNC_WRITE_A ? dims[CFG_A_COLS] : dims[CFG_B_COLS]);
          if (row >= n_rows || col >= n_cols) begin
            push_result(STATUS_INDEX_ERR, row, col, '0, 1'b1);
            index_errs_due++;
          end else if (func == FUNC_WRITE_A) begin
            mat_a[row*MAX_DIM_DEF + col] = value;
          end else begin
            mat_b[row*MAX_DIM_DEF + col] = value;
          end
        end
        FUNC_COMPUTE: begin
          computes_done++;
          m     = dim_of(dims[CFG_A_ROWS]);
          inner = dim_of(dims[CFG_A_COLS]);
          n     = dim_of(dims[CFG_B_COLS]);
          if (inner != dim_of(dims[CFG_B_ROWS])) begin
            push_result(STATUS_DIM_ERR, 0, 0, '0, 1'b1);
            dim_errs_due++;
          end else begin
            for (int unsigned i = 0; i < m; i++) begin
              for (int unsigned j = 0; j < n; j++) begin
                acc = '0;
                // The truncated 32-bit product is the same for signed operands.
                for (int unsigned k = 0; k < inner; k++)
                  acc = acc + mat_a[i*MAX_DIM_DEF + k] * mat_b[k*MAX_DIM_DEF + j];
                push_result(STATUS_OK, i, j, acc, (i == m - 1) && (j == n - 1));
                products_due++;
              end
            end
          end
        end
        default: ignored_done++;
      endcase
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_output(logic [STATUS_W-1:0] status, logic [POS_W-1:0] row,
                      logic [POS_W-1:0] col, logic [VAL_W-1:0] value,
                      logic last);
      mm_result_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d row %0d col %0d value %h",
                                  status, row, col, value));
        return;
      end
      want = results_due.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (row !== want.row)
        report_mismatch($sformatf("row %0d, expected %0d", row, want.row));
      if (col !== want.col)
        report_mismatch($sformatf("col %0d, expected %0d", col, want.col));
      if (value !== want.value)
        report_mismatch($sformatf("value %h, expected %h at row %0d col %0d",
                                  value, want.value, want.row, want.col));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b at row %0d col %0d",
                                  last, want.last, want.row, want.col));
    endtask
  endclass

endpackage

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imm_pkg::*;
  import matmul_tracker_pkg::*;

  localparam int unsigned TOTAL_ITEMS    = 280;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [REG_W-1:0]        cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [FUNC_W-1:0]       func_i;
  logic [POS_W-1:0]        row_index_i;
  logic [POS_W-1:0]        col_index_i;
  logic signed [VAL_W-1:0] element_value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [STATUS_W-1:0]     status_o;
  logic [POS_W-1:0]        out_row_o;
  logic [POS_W-1:0]        out_col_o;
  logic signed [VAL_W-1:0] out_value_o;
  logic                    last_o;

  matmul_tracker tracker;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   items_sent;
  int unsigned   quiet_cycles;
  bit            hold_request;

  integer_matrix_multiply_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .out_value_o     (out_value_o),
    .last_o          (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Both transfers of a cycle are handled here, the input first, so that a
  // result can never be checked ahead of the command that caused it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        tracker.apply_command(func_i, row_index_i, col_index_i, element_value_i);
      if (out_valid_o && out_ready_i)
        tracker.check_output(status_o, out_row_o, out_col_o, out_value_o, last_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3, 4, 5: return VAL_W'(int'($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sizes; now and then zero, full size or a value past it.
  function automatic logic [REG_W-1:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 6) return 4'd0;
    if (roll < 14) return 4'd8;
    if (roll < 20) return REG_W'($urandom_range(15, 9));
    return REG_W'($urandom_range(3, 1));
  endfunction

  // Valid stays high from one command to the next unless the sender idles.
  task automatic send_item(logic [FUNC_W-1:0] func, int unsigned row, int unsigned col,
                           logic [VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= func;
    row_index_i     <= POS_W'(row);
    col_index_i     <= POS_W'(col);
    element_value_i <= value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic send_noise();
    send_item(FUNC_W'($urandom_range(3)), $urandom_range(7), $urandom_range(7),
              rand_value());
  endtask

  // Stop offering, wait for every outstanding result, then give a command
  // that produces nothing time to finish before the registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [REG_W-1:0] a_rows, logic [REG_W-1:0] a_cols,
                           logic [REG_W-1:0] b_rows, logic [REG_W-1:0] b_cols);
    logic [REG_W-1:0] vals [4];
    vals[CFG_A_ROWS] = a_rows;
    vals[CFG_A_COLS] = a_cols;
    vals[CFG_B_ROWS] = b_rows;
    vals[CFG_B_COLS] = b_cols;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      tracker.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_matrix(logic [FUNC_W-1:0] func, int unsigned rows, int unsigned cols,
                             bit with_noise);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        if (with_noise && $urandom_range(99) < 8) send_noise();
        send_item(func, r, c, rand_value());
      end
    end
  endtask

  task automatic random_sequence();
    logic [REG_W-1:0] ar, ac, br, bc;
    ar = pick_dim();
    ac = pick_dim();
    bc = pick_dim();
    br = ($urandom_range(99) < 85) ? ac : pick_dim();
    settle();
    configure(ar, ac, br, bc);
    if ($urandom_range(99) < 80) begin
      fill_matrix(FUNC_WRITE_A, tracker.dim_of(ar), tracker.dim_of(ac), 1'b1);
      fill_matrix(FUNC_WRITE_B, tracker.dim_of(br), tracker.dim_of(bc), 1'b1);
      send_item(FUNC_COMPUTE, $urandom_range(7), $urandom_range(7), rand_value());
      // Sometimes touch up a few elements and multiply again.
      if ($urandom_range(1) == 1) begin
        repeat ($urandom_range(3, 1)) begin
          send_item(FUNC_W'($urandom_range(1)), $urandom_range(3), $urandom_range(3),
                    rand_value());
        end
        send_item(FUNC_COMPUTE, 0, 0, '0);
      end
    end else begin
      repeat ($urandom_range(12, 4)) send_noise();
      send_item(FUNC_COMPUTE, $urandom_range(7), $urandom_range(7), rand_value());
    end
  endtask

  // The output side holds off while a 16-element product is requested and
  // more commands queue up behind it.
  task automatic output_hold_test();
    settle();
    configure(4'd4, 4'd2, 4'd2, 4'd4);
    fill_matrix(FUNC_WRITE_A, 4, 2, 1'b0);
    fill_matrix(FUNC_WRITE_B, 2, 4, 1'b0);
    hold_request = 1'b1;
    send_item(FUNC_COMPUTE, 0, 0, '0);
    send_item(FUNC_WRITE_A, 0, 0, rand_value());
    send_item(FUNC_WRITE_A, 3, 1, rand_value());
    send_item(FUNC_WRITE_B, 1, 3, rand_value());
    send_item(FUNC_COMPUTE, 0, 0, '0);
  endtask

  task automatic directed_checks();
    // Stores read as zero straight after reset.
    send_item(FUNC_COMPUTE, 0, 0, '0);
    send_item(FUNC_WRITE_A, 0, 0, 32'h8000_0000);
    send_item(FUNC_WRITE_B, 0, 0, 32'hFFFF_FFFF);
    send_item(FUNC_COMPUTE, 7, 7, 32'hFFFF_FFFF);
    send_item(FUNC_WRITE_A, 7, 7, 32'h1234_5678);
    send_item(FUNC_WRITE_B, 0, 1, 32'h0000_0001);
    send_item(FUNC_UNUSED, 7, 7, 32'h7FFF_FFFF);
    send_item(FUNC_WRITE_A, 0, 0, 32'h7FFF_FFFF);
    send_item(FUNC_COMPUTE, 0, 0, '0);

    // Inner dimensions disagree.
    settle();
    configure(4'd1, 4'd2, 4'd1, 4'd1);
    send_item(FUNC_COMPUTE, 0, 0, '0);

    // No rows of A: nothing is produced and every write to A misses.
    settle();
    configure(4'd0, 4'd1, 4'd1, 4'd1);
    send_item(FUNC_COMPUTE, 0, 0, '0);
    send_item(FUNC_WRITE_A, 0, 0, 32'h0000_0005);

    // Empty inner dimension: a full grid of zeros.
    settle();
    configure(4'd15, 4'd0, 4'd0, 4'd15);
    send_item(FUNC_COMPUTE, 0, 0, '0);
    send_item(FUNC_WRITE_B, 7, 7, 32'hFFFF_FFFD);

    // Oversized registers clamp to the full size, so 9 and 8 agree.
    settle();
    configure(4'd15, 4'd9, 4'd8, 4'd15);
    send_item(FUNC_WRITE_A, 7, 7, 32'h0000_0005);
    send_item(FUNC_WRITE_A, 7, 0, 32'h7FFF_FFFF);
    send_item(FUNC_WRITE_B, 7, 7, 32'hFFFF_FFFD);
    send_item(FUNC_WRITE_B, 0, 7, 32'h0000_0002);
    send_item(FUNC_COMPUTE, 0, 0, '0);
  endtask

  initial begin
    tracker         = new();
    send_idle_pct   = 11;
    recv_idle_pct   = 78;
    items_sent      = 0;
    quiet_cycles    = 0;
    hold_request    = 1'b0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_A_ROWS;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    func_i          <= FUNC_WRITE_A;
    row_index_i     <= '0;
    col_index_i     <= '0;
    element_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_checks();

    // The first two phases each run at least one sequence, however large the last one was.
    do random_sequence(); while (items_sent < TOTAL_ITEMS / 3);
    send_idle_pct = 78;
    recv_idle_pct = 11;
    do random_sequence(); while (items_sent < 2 * TOTAL_ITEMS / 3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    output_hold_test();
    while (items_sent < TOTAL_ITEMS) random_sequence();

    settle();
    $display("Sent %0d writes and %0d products requested (%0d ignored commands); saw %0d",
             tracker.writes_done, tracker.computes_done, tracker.ignored_done,
             tracker.products_due);
    $display("product elements, %0d index errors and %0d dimension errors.",
             tracker.index_errs_due, tracker.dim_errs_due);
    if (tracker.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", tracker.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
